[hdl/dsp_pkg.sv]
package dsp_pkg;

   localparam int DIST_BITS = 22;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_EDGE  = 2'd1,
      OP_RUN   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      logic clr_start;
      logic lbl_clear;
      logic set_src;
      logic edge_wr;
      logic relax_rd;
      logic relax_do;
      logic settle;
      logic sel_step;
      logic sel_init;
      logic take_best;
      logic query;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic scan_last;
      logic found;
      logic src_ok;
   } stat_type;

endpackage

[hdl/dense_shortest_path_engine.sv]
// Edge write goes through the finish state, query through the query state; clear sweeps the
// whole matrix. Run: per settled vertex, a read and a relax step for each vertex (one matrix
// read port), then a select scan and a pick; no new item is taken until the current one is done.
// Reset: synchronous; clears labels and sweeps the matrix (MAX_VERTICES^2 entries for a
// power of two), during which no item is taken; vertex_count resets to 64.
module dense_shortest_path_engine #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // operation, vertex_a, vertex_b, edge_weight, zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // distance, predecessor, has_predecessor, reached, zeros
   input  logic        csr_wen,
   input  logic [6:0]  csr_wdata
);
   import dsp_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic idle, done, start;
   logic [6:0] vcount_ff;
   logic [DIST_BITS-1:0] q_dist;
   logic [5:0] q_pred;
   logic q_hp, q_r;
   logic [31:0] rsp_ff;
   logic rsp_valid_ff;
   logic [29:0] req_ff;
   logic [29:0] req_cur;
   op_type op;

   assign op = op_type'(req_tdata[1:0]);
   assign req_tready = idle && stat.clr_done;
   assign start = req_tvalid && req_tready;

   // fields held for the whole item once the transfer is taken
   always_ff @(posedge clock) begin
      if (start) req_ff <= req_tdata[29:0];
   end
   assign req_cur = start ? req_tdata[29:0] : req_ff;

   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= 7'd64;
      else if (csr_wen) vcount_ff <= csr_wdata;
   end

   dsp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(op), .stat(stat),
      .rsp_busy(rsp_valid_ff && !rsp_tready), .cmd(cmd), .idle(idle), .done(done)
   );

   dsp_datapath #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .vcount(vcount_ff),
      .vertex_a(req_cur[7:2]), .vertex_b(req_cur[13:8]), .edge_weight(req_cur[29:14]),
      .stat(stat), .q_dist(q_dist), .q_pred(q_pred), .q_has_pred(q_hp), .q_reached(q_r)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (done) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
      if (done) rsp_ff <= cmd.query ? {2'b0, q_r, q_hp, q_pred, q_dist} : '0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      !idle |-> !req_tready) else $error("accept while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> idle) else $error("not idle after done");
   a_nohp_unreached: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[29] |-> !rsp_tdata[28]) else $error("pred without reach");
endmodule

[hdl/dsp_ctrl.sv]
module dsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dsp_pkg::op_type   op,
   input  dsp_pkg::stat_type stat,
   input  logic              rsp_busy,
   output dsp_pkg::cmd_type  cmd,
   output logic              idle,
   output logic              done
);
   import dsp_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CLEAR  = 9'b000000010,
      S_SRC    = 9'b000000100,
      S_RELAX  = 9'b000001000,
      S_WAIT   = 9'b000010000,
      S_SEL    = 9'b000100000,
      S_PICK   = 9'b001000000,
      S_FINISH = 9'b010000000,
      S_QUERY  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      done = 1'b0;
      idle = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (op)
                  OP_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     cmd.lbl_clear = 1'b1;
                     state_in = S_CLEAR;
                  end
                  OP_EDGE: begin
                     cmd.edge_wr = 1'b1;
                     state_in = S_FINISH;
                  end
                  OP_RUN: begin
                     cmd.lbl_clear = 1'b1;
                     state_in = S_SRC;
                  end
                  OP_QUERY: state_in = S_QUERY;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: if (stat.clr_done) state_in = S_FINISH;
         S_SRC: begin
            cmd.set_src = 1'b1;
            state_in = stat.src_ok ? S_RELAX : S_FINISH;
         end
         S_RELAX: begin
            cmd.relax_rd = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.relax_do = 1'b1;
            if (stat.scan_last) begin
               cmd.settle = 1'b1;
               cmd.sel_init = 1'b1;
               state_in = S_SEL;
            end else state_in = S_RELAX;
         end
         S_SEL: begin
            cmd.sel_step = 1'b1;
            if (stat.scan_last) state_in = S_PICK;
         end
         S_PICK: begin
            if (stat.found) begin
               cmd.take_best = 1'b1;
               state_in = S_RELAX;
            end else state_in = S_FINISH;
         end
         S_QUERY: begin
            if (!rsp_busy) begin
               cmd.query = 1'b1;
               done = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (!rsp_busy) begin
               done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

[hdl/dsp_datapath.sv]
module dsp_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsp_pkg::cmd_type              cmd,
   input  logic [6:0]                    vcount,
   input  logic [5:0]                    vertex_a,
   input  logic [5:0]                    vertex_b,
   input  logic [15:0]                   edge_weight,
   output dsp_pkg::stat_type             stat,
   output logic [dsp_pkg::DIST_BITS-1:0] q_dist,
   output logic [5:0]                    q_pred,
   output logic                          q_has_pred,
   output logic                          q_reached
);
   import dsp_pkg::*;

   localparam int VB = $clog2(MAX_VERTICES);
   localparam int AB = 2 * VB;
   localparam int MD = 1 << AB;
   localparam int EW = WEIGHT_BITS + 1;
   localparam int CB = (VB + 1 > 7) ? VB + 1 : 7;

   logic [EW-1:0] mem [MD];
   logic [EW-1:0] rd_ff;

   logic [DIST_BITS-1:0] dist_ff [MAX_VERTICES];
   logic [VB-1:0]        pred_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] reach_ff, hpred_ff, done_ff, front_ff;

   logic [AB-1:0] clr_ff, clr_in;
   logic          clr_run_ff;
   logic [VB-1:0] cur_ff, j_ff, j_in, best_ff;
   logic          found_ff;
   logic [CB-1:0] n_eff;
   logic [CB-1:0] a_ext, b_ext;
   logic [VB-1:0] a_idx, b_idx;
   logic          mem_we;
   logic [AB-1:0] mem_wa;
   logic [EW-1:0] mem_wd;
   logic [DIST_BITS:0] sum;
   logic [DIST_BITS-1:0] cand;
   logic          relax_ok, better, sel_ok;
   logic [VB-1:0] d_ra;
   logic [DIST_BITS-1:0] d_rd_ff, cur_dist_ff, best_dist_ff;
   logic [VB-1:0] p_rd_ff;

   assign n_eff = (CB'(vcount) > CB'(MAX_VERTICES)) ? CB'(MAX_VERTICES) : CB'(vcount);
   assign a_ext = CB'(vertex_a);
   assign b_ext = CB'(vertex_b);
   assign a_idx = VB'(vertex_a);
   assign b_idx = VB'(vertex_b);

   assign mem_we = clr_run_ff || (cmd.edge_wr && a_ext < n_eff && b_ext < n_eff);
   assign mem_wa = clr_run_ff ? clr_ff : {a_idx, b_idx};
   assign mem_wd = clr_run_ff ? '0 : {1'b1, WEIGHT_BITS'(edge_weight)};

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.relax_rd) rd_ff <= mem[{cur_ff, j_ff}];
   end

   assign clr_in = clr_ff + 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_run_ff <= 1'b1;
         clr_ff <= '0;
      end else if (cmd.clr_start) begin
         clr_run_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clr_run_ff) begin
         clr_ff <= clr_in;
         if (clr_ff == AB'(MD - 1)) clr_run_ff <= 1'b0;
      end
   end

   assign sum = (DIST_BITS+1)'(cur_dist_ff) + (DIST_BITS+1)'(rd_ff[WEIGHT_BITS-1:0]);
   assign cand = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
   assign relax_ok = rd_ff[EW-1] && j_ff != cur_ff && !done_ff[j_ff];
   assign better = !reach_ff[j_ff] || cand < d_rd_ff;
   assign sel_ok = front_ff[j_ff] && reach_ff[j_ff] && j_ff != cur_ff &&
                   (!found_ff || d_rd_ff < best_dist_ff);

   assign stat.scan_last = (CB'(j_ff) == n_eff - 1'b1);
   assign stat.clr_done  = !clr_run_ff;
   assign stat.found     = found_ff;
   assign stat.src_ok    = a_ext < n_eff;
   assign j_in = stat.scan_last ? '0 : j_ff + 1'b1;

   // single registered read port on the labels: relax reads j, select prefetches next j
   assign d_ra = cmd.relax_rd ? j_ff : (cmd.sel_init || cmd.sel_step) ? j_in : a_idx;

   always_ff @(posedge clock) begin
      if (reset || cmd.lbl_clear) begin
         reach_ff <= '0;
         hpred_ff <= '0;
         done_ff  <= '0;
         front_ff <= '0;
      end else begin
         if (cmd.set_src && stat.src_ok) reach_ff[a_idx] <= 1'b1;
         if (cmd.relax_do && relax_ok) begin
            front_ff[j_ff] <= 1'b1;
            if (better) begin
               reach_ff[j_ff] <= 1'b1;
               hpred_ff[j_ff] <= 1'b1;
            end
         end
         if (cmd.settle) begin
            front_ff[cur_ff] <= 1'b0;
            done_ff[cur_ff]  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_rd_ff <= dist_ff[d_ra];
      p_rd_ff <= pred_ff[d_ra];
      if (cmd.set_src) begin
         dist_ff[a_idx] <= '0;
         cur_dist_ff <= '0;
         cur_ff <= a_idx;
         j_ff <= '0;
      end
      if (cmd.relax_do) begin
         if (relax_ok && better) begin
            dist_ff[j_ff] <= cand;
            pred_ff[j_ff] <= cur_ff;
         end
         j_ff <= j_in;
      end
      if (cmd.sel_init) found_ff <= 1'b0;
      if (cmd.sel_step) begin
         if (sel_ok) begin
            best_ff <= j_ff;
            best_dist_ff <= d_rd_ff;
            found_ff <= 1'b1;
         end
         j_ff <= j_in;
      end
      if (cmd.take_best) begin
         cur_ff <= best_ff;
         cur_dist_ff <= best_dist_ff;
         j_ff <= '0;
      end
   end

   always_comb begin
      q_dist = '0;
      q_pred = '0;
      q_has_pred = 1'b0;
      q_reached = 1'b0;
      if (a_ext < n_eff && reach_ff[a_idx]) begin
         q_dist = d_rd_ff;
         q_reached = 1'b1;
         if (hpred_ff[a_idx]) begin
            q_pred = 6'(p_rd_ff);
            q_has_pred = 1'b1;
         end
      end
   end
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import dsp_pkg::*;

   localparam int NV = 64;
   localparam logic [21:0] DMAX = 22'h3FFFFF;

   typedef struct packed {
      op_type      op;
      logic [5:0]  a;
      logic [5:0]  b;
      logic [15:0] w;
      logic        lit;
      logic [31:0] rsp;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [6:0] csr_wdata = '0;

   bit quiet = 0;
   bit hold_rsp = 0;
   int mismatches = 0;

   // model of the engine
   logic [15:0] m_wt [NV*NV];
   bit          m_ev [NV*NV];
   logic [21:0] m_dist [NV];
   bit          m_reach [NV];
   logic [5:0]  m_pred [NV];
   bit          m_hasp [NV];
   bit          m_done [NV];
   bit          m_front [NV];
   logic [6:0]  m_count;

   logic [31:0] rsp_expected [$];
   bit          lit_pending [$];
   logic [31:0] lit_value [$];
   row_t        dir_tab [$];

   always #5 clock = ~clock;

   dense_shortest_path_engine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   function automatic logic [31:0] pack_rsp(logic [21:0] d, logic [5:0] p, bit hp, bit r);
      return {2'b00, r, hp, p, d};
   endfunction

   function automatic int active_n();
      return (m_count > NV) ? NV : int'(m_count);
   endfunction

   function automatic void clear_labels();
      for (int i = 0; i < NV; i++) begin
         m_dist[i] = '0; m_reach[i] = 0; m_pred[i] = '0;
         m_hasp[i] = 0; m_done[i] = 0; m_front[i] = 0;
      end
   endfunction

   function automatic void clear_matrix();
      for (int i = 0; i < NV*NV; i++) begin
         m_wt[i] = '0; m_ev[i] = 0;
      end
   endfunction

   function automatic void settle_from(int src);
      int n, cur, best, idx;
      bit found;
      logic [22:0] sum;
      logic [21:0] cand;
      n = active_n();
      cur = src;
      clear_labels();
      if (src >= n) return;
      m_reach[src] = 1;
      forever begin
         found = 0;
         best = 0;
         for (int j = 0; j < n; j++) begin
            idx = cur*NV + j;
            if (m_ev[idx] && j != cur && !m_done[j]) begin
               sum = {1'b0, m_dist[cur]} + {7'b0, m_wt[idx]};
               cand = (sum > DMAX) ? DMAX : sum[21:0];
               m_front[j] = 1;
               if (!m_reach[j] || cand < m_dist[j]) begin
                  m_dist[j] = cand; m_reach[j] = 1;
                  m_pred[j] = cur[5:0]; m_hasp[j] = 1;
               end
            end
         end
         m_front[cur] = 0;
         m_done[cur] = 1;
         for (int j = 0; j < n; j++)
            if (m_front[j] && m_reach[j] && j != cur &&
                (!found || m_dist[j] < m_dist[best])) begin
               best = j; found = 1;
            end
         if (!found) break;
         cur = best;
      end
   endfunction

   function automatic logic [31:0] predict_rsp(logic [31:0] d);
      op_type op;
      int a, b, n;
      logic [31:0] r;
      op = op_type'(d[1:0]);
      a = int'(d[7:2]);
      b = int'(d[13:8]);
      n = active_n();
      r = '0;
      case (op)
         OP_CLEAR: begin
            clear_matrix(); clear_labels();
         end
         OP_EDGE: begin
            if (a < n && b < n) begin
               m_wt[a*NV+b] = d[29:14]; m_ev[a*NV+b] = 1;
            end
         end
         OP_RUN: settle_from(a);
         default: begin
            if (a < n && m_reach[a])
               r = pack_rsp(m_dist[a], m_hasp[a] ? m_pred[a] : 6'd0, m_hasp[a], 1'b1);
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      logic [31:0] e, pm;
      bit lit;
      if (reset) begin
         clear_matrix(); clear_labels(); m_count = 7'd64;
      end else begin
         if (csr_wen) m_count = csr_wdata;
         if (req_tvalid && req_tready) begin
            pm = predict_rsp(req_tdata);
            lit = lit_pending.pop_front();
            e = lit_value.pop_front();
            rsp_expected.push_back(lit ? e : pm);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer %h", rsp_tdata);
            end else begin
               e = rsp_expected.pop_front();
               if (rsp_tdata[21:0] !== e[21:0] || rsp_tdata[27:22] !== e[27:22] ||
                   rsp_tdata[28] !== e[28] || rsp_tdata[29] !== e[29] ||
                   rsp_tdata[31:30] !== 2'b00) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: dist %0d/%0d pred %0d/%0d hp %b/%b r %b/%b",
                              e[21:0], rsp_tdata[21:0], e[27:22], rsp_tdata[27:22],
                              e[28], rsp_tdata[28], e[29], rsp_tdata[29]);
               end
            end
         end
      end
   end

   // receiver
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready = 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready = 1;
         @(negedge clock);
      end
   end

   task automatic send(op_type op, logic [5:0] a, logic [5:0] b, logic [15:0] w,
                       bit lit = 0, logic [31:0] rv = '0);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      lit_pending.push_back(lit);
      lit_value.push_back(rv);
      req_tdata = {2'b00, w, b, a, op};
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (rsp_expected.size() != 0 || lit_pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_count(logic [6:0] v);
      drain();
      csr_wdata = v;
      csr_wen = 1;
      @(negedge clock);
      csr_wen = 0;
   endtask

   function automatic logic [5:0] pick(int n);
      if (n < 1 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      return 6'($urandom_range(0, n-1));
   endfunction

   task automatic random_phase(int n, int items);
      int r;
      logic [15:0] w;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
         if (r < 50)      send(OP_EDGE, pick(n), pick(n), w);
         else if (r < 62) send(OP_RUN, pick(n), 6'($urandom), 16'($urandom));
         else if (r < 97) send(OP_QUERY, pick(n), 6'($urandom), 16'($urandom));
         else             send(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
      end
   endtask

   function automatic row_t row(op_type op, int a, int b, int w, int lit = 0,
                                logic [31:0] rv = '0);
      row_t t;
      t.op = op; t.a = 6'(a); t.b = 6'(b); t.w = 16'(w); t.lit = (lit != 0); t.rsp = rv;
      return t;
   endfunction

   initial begin
      dir_tab.push_back(row(OP_QUERY, 0, 0, 0, 1, '0));
      dir_tab.push_back(row(OP_EDGE, 0, 1, 65535, 1, '0));
      dir_tab.push_back(row(OP_EDGE, 1, 2, 65535, 1, '0));
      dir_tab.push_back(row(OP_EDGE, 0, 63, 0, 1, '0));
      dir_tab.push_back(row(OP_EDGE, 5, 5, 7, 1, '0));
      dir_tab.push_back(row(OP_EDGE, 2, 0, 10));
      dir_tab.push_back(row(OP_EDGE, 0, 3, 5));
      dir_tab.push_back(row(OP_EDGE, 0, 4, 5));
      dir_tab.push_back(row(OP_EDGE, 3, 6, 1));
      dir_tab.push_back(row(OP_EDGE, 4, 6, 1));
      dir_tab.push_back(row(OP_RUN, 0, 0, 0, 1, '0));
      dir_tab.push_back(row(OP_QUERY, 1, 0, 0, 1,
                            pack_rsp(22'd65535, 6'd0, 1'b1, 1'b1)));
      dir_tab.push_back(row(OP_QUERY, 2, 0, 0, 1,
                            pack_rsp(22'd131070, 6'd1, 1'b1, 1'b1)));
      dir_tab.push_back(row(OP_QUERY, 63, 0, 0, 1, pack_rsp(22'd0, 6'd0, 1'b1, 1'b1)));
      dir_tab.push_back(row(OP_QUERY, 0, 0, 0, 1, pack_rsp(22'd0, 6'd0, 1'b0, 1'b1)));
      dir_tab.push_back(row(OP_QUERY, 5, 0, 0, 1, '0));
      dir_tab.push_back(row(OP_QUERY, 6, 0, 0));
      dir_tab.push_back(row(OP_RUN, 63, 0, 0));
      dir_tab.push_back(row(OP_QUERY, 63, 0, 0, 1, pack_rsp(22'd0, 6'd0, 1'b0, 1'b1)));
      dir_tab.push_back(row(OP_QUERY, 1, 0, 0, 1, '0));
      dir_tab.push_back(row(OP_CLEAR, 63, 63, 65535, 1, '0));
      dir_tab.push_back(row(OP_QUERY, 63, 0, 0, 1, '0));
      dir_tab.push_back(row(OP_RUN, 0, 0, 0));
      dir_tab.push_back(row(OP_QUERY, 1, 0, 0, 1, '0));

      repeat (9) @(negedge clock);
      reset = 0;

      foreach (dir_tab[i])
         send(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w,
              dir_tab[i].lit, dir_tab[i].rsp);

      // edges and sources beyond a lowered count
      set_count(7'd3);
      send(OP_EDGE, 6'd5, 6'd1, 16'd2, 1'b1, '0);
      send(OP_EDGE, 6'd1, 6'd2, 16'd3);
      send(OP_RUN, 6'd5, 6'd0, 16'd0);
      send(OP_QUERY, 6'd5, 6'd0, 16'd0, 1'b1, '0);
      send(OP_RUN, 6'd1, 6'd0, 16'd0);
      send(OP_QUERY, 6'd2, 6'd0, 16'd0);
      random_phase(3, 20);

      set_count(7'd1);
      random_phase(1, 12);

      // receiver held off while items keep coming
      set_count(7'd2);
      hold_rsp = 1;
      random_phase(2, 20);

      set_count(7'd8);
      random_phase(8, 15);

      set_count(7'd64);
      random_phase(64, 18);

      set_count(7'd13);
      random_phase(13, 12);
      quiet = 1;
      random_phase(13, 12);

      drain();
      repeat (100) @(negedge clock);
      if (mismatches == 0 && rsp_expected.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(64'd300_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
